// File: src/segsum_pkg.sv
// ----------------------------------------------------------------------------
// segsum_pkg
// Shared types and constants of the segment tree range sum unit: field
// widths, the request opcode and the control word that moves along the cells.
// ----------------------------------------------------------------------------
package segsum_pkg;

    localparam int LEAF_W = 10;
    localparam int DATA_W = 32;

    typedef enum logic {
        OP_SET   = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    // control word handed from cell to cell with each request
    typedef struct packed {
        logic valid;
        logic query;   // range sum request
        logic write;   // set request whose leaf is inside the tree
        logic hi_l;    // left / set pointer starts one level below the usual leaf level
        logic hi_r;    // same for the right pointer
    } tok_ctrl_t;

endpackage

// File: src/segsum_ram.sv
// ----------------------------------------------------------------------------
// segsum_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module segsum_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_a_reg;
    logic [WIDTH-1:0] rd_data_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a_reg <= mem[rd_addr_a];
        rd_data_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

// File: src/segsum_cell.sv
// ----------------------------------------------------------------------------
// segsum_cell
// One tree level. Holds the node sums of its level in a small RAM, reads the
// nodes that the passing request needs, and on the next cycle updates the
// running sum or writes the new node value before handing the request on.
// ----------------------------------------------------------------------------
module segsum_cell #(
    parameter int LEAVES = 1024,
    parameter int LEVEL  = 0
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  segsum_pkg::tok_ctrl_t                 in_ctrl,
    input  logic [$clog2(2*LEAVES)-1:0]           in_lp,
    input  logic [$clog2(2*LEAVES)-1:0]           in_rp,
    input  logic [segsum_pkg::DATA_W-1:0]         in_acc,
    input  logic                                  clr_en,
    input  logic [(($clog2(2*LEAVES)-1 > 1) ? ($clog2(2*LEAVES)-1) : 1)-1:0] clr_addr,
    output segsum_pkg::tok_ctrl_t                 out_ctrl,
    output logic [$clog2(2*LEAVES)-1:0]           out_lp,
    output logic [$clog2(2*LEAVES)-1:0]           out_rp,
    output logic [segsum_pkg::DATA_W-1:0]         out_acc
);

    import segsum_pkg::*;

    localparam int PW   = $clog2(2*LEAVES);
    localparam int HL   = $clog2(LEAVES+1) - 1;
    localparam int AW   = (LEVEL > 1) ? LEVEL : 1;
    localparam int K1   = HL + 1 - LEVEL;
    localparam int K0   = (HL >= LEVEL) ? (HL - LEVEL) : 0;
    localparam bit LOW_OK  = (HL >= LEVEL);
    localparam bit LEAF_LO = (LEVEL == HL);
    localparam bit LEAF_HI = (LEVEL == HL + 1);

    tok_ctrl_t         ctrl_reg;
    logic [PW-1:0]     lp_reg;
    logic [PW-1:0]     rp_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [AW-1:0]     addr_w_reg;
    logic              take_l_reg;
    logic              take_r_reg;

    logic [PW-1:0]     xl;
    logic [PW-1:0]     xr;
    logic [PW-1:0]     rl;
    logic [PW-1:0]     lr;
    logic [PW-1:0]     addr_l;
    logic [PW-1:0]     addr_r;
    logic              present_l;
    logic              present_r;
    logic              take_l;
    logic              take_r;

    logic [DATA_W-1:0] rd_a;
    logic [DATA_W-1:0] rd_b;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              st_present;
    logic              st_leaf;

    // node of each path on this level, and both pointers one level further up
    always_comb
    begin
        xl = in_ctrl.hi_l ? (in_lp >> K1) : (in_lp >> K0);
        rl = in_ctrl.hi_l ? (in_rp >> (K1 + 1)) : (in_rp >> (K0 + 1));
        xr = in_ctrl.hi_r ? (in_rp >> K1) : (in_rp >> K0);
        lr = in_ctrl.hi_r ? (in_lp >> (K1 + 1)) : (in_lp >> (K0 + 1));

        present_l = in_ctrl.hi_l | LOW_OK;
        present_r = in_ctrl.hi_r | LOW_OK;

        // left bound takes its right sibling, right bound its left sibling
        take_l = in_ctrl.valid & in_ctrl.query & present_l & ~xl[0] & ((xl >> 1) < rl);
        take_r = in_ctrl.valid & in_ctrl.query & present_r & xr[0] & (lr < (xr >> 1));

        addr_l = in_ctrl.query ? {xl[PW-1:1], 1'b1} : xl;
        addr_r = {xr[PW-1:1], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg   <= '0;
            take_l_reg <= 1'b0;
            take_r_reg <= 1'b0;
        end
        else
        begin
            ctrl_reg   <= in_ctrl;
            take_l_reg <= take_l;
            take_r_reg <= take_r;
        end
    end

    always_ff @(posedge clk)
    begin
        lp_reg     <= in_lp;
        rp_reg     <= in_rp;
        acc_reg    <= in_acc;
        addr_w_reg <= addr_l[AW-1:0];
    end

    segsum_ram #(
        .WIDTH (DATA_W),
        .DEPTH (2**AW)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (addr_l[AW-1:0]),
        .rd_addr_b (addr_r[AW-1:0]),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    always_comb
    begin
        st_present = ctrl_reg.hi_l | LOW_OK;
        st_leaf    = ctrl_reg.hi_l ? LEAF_HI : LEAF_LO;

        wr_en   = clr_en | (ctrl_reg.valid & ctrl_reg.write & st_present);
        wr_addr = clr_en ? clr_addr[AW-1:0] : addr_w_reg;
        if (clr_en)
        begin
            wr_data = '0;
        end
        else if (st_leaf)
        begin
            wr_data = acc_reg;
        end
        else
        begin
            wr_data = rd_a + acc_reg;
        end

        // set: the leaf level turns the new value into the difference
        if (ctrl_reg.query)
        begin
            out_acc = acc_reg + (take_l_reg ? rd_a : '0) + (take_r_reg ? rd_b : '0);
        end
        else if (st_present & st_leaf)
        begin
            out_acc = acc_reg - rd_a;
        end
        else
        begin
            out_acc = acc_reg;
        end
    end

    assign out_ctrl = ctrl_reg;
    assign out_lp   = lp_reg;
    assign out_rp   = rp_reg;

endmodule

// File: src/segment_tree_point_set_range_sum_unit.sv
// ----------------------------------------------------------------------------
// segment_tree_point_set_range_sum_unit
// Bottom-up segment tree with point set and exclusive range sum requests.
//
//   channel   handshake         payload
//   request   start / busy      opcode, left_leaf, right_leaf, new_value
//   result    done (strobe)     range_sum
//
// A request walks a chain of clog2(LEAVES)+1 level cells, one cell per cycle,
// each cell reading two nodes and writing at most one of its own level RAM;
// busy stays high until the request leaves the root cell, so the next request
// is accepted only then, and done rises as busy falls. After reset the level
// RAMs are cleared in parallel, with busy high until every address is written.
// Results cannot be held off: done is high for exactly one cycle per query.
// ----------------------------------------------------------------------------
module segment_tree_point_set_range_sum_unit #(
    parameter int LEAVES = 1024
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic                                    opcode,
    input  logic [segsum_pkg::LEAF_W-1:0]           left_leaf,
    input  logic [segsum_pkg::LEAF_W-1:0]           right_leaf,
    input  logic signed [segsum_pkg::DATA_W-1:0]    new_value,
    output logic                                    done,
    output logic signed [segsum_pkg::DATA_W-1:0]    range_sum
);

    import segsum_pkg::*;

    localparam int PW   = $clog2(2*LEAVES);
    localparam int HL   = $clog2(LEAVES+1) - 1;
    localparam int NL   = PW;
    localparam int HMAX = PW - 1;
    localparam int CW   = (HMAX > 1) ? HMAX : 1;
    localparam int unsigned LEAVES_U = LEAVES;
    localparam logic [LEAF_W-1:0] LEAF_LAST = LEAF_W'(LEAVES - 1);
    localparam logic [PW-1:0]     BASE      = PW'(LEAVES);

    tok_ctrl_t         chain_ctrl [NL+1];
    logic [PW-1:0]     chain_lp   [NL+1];
    logic [PW-1:0]     chain_rp   [NL+1];
    logic [DATA_W-1:0] chain_acc  [NL+1];

    logic              clearing_reg;
    logic [CW-1:0]     clr_cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DATA_W-1:0] range_sum_reg;

    logic              accept;
    logic              is_query;
    logic [LEAF_W-1:0] lo_c;
    logic [LEAF_W-1:0] hi_c;
    logic [PW-1:0]     ptr_l;
    logic [PW-1:0]     ptr_r;

    assign accept = start & ~busy;

    // leaf pointers; query bounds past the end saturate to the last leaf
    always_comb
    begin
        is_query = (opcode == OP_QUERY);
        lo_c     = (32'(left_leaf) < LEAVES_U) ? left_leaf : LEAF_LAST;
        hi_c     = (32'(right_leaf) < LEAVES_U) ? right_leaf : LEAF_LAST;
        ptr_l    = BASE + PW'(lo_c);
        ptr_r    = BASE + PW'(hi_c);

        chain_ctrl[NL].valid = accept;
        chain_ctrl[NL].query = is_query;
        chain_ctrl[NL].write = ~is_query & (32'(left_leaf) < LEAVES_U);
        chain_ctrl[NL].hi_l  = (ptr_l >> (HL + 1)) != '0;
        chain_ctrl[NL].hi_r  = (ptr_r >> (HL + 1)) != '0;
        chain_lp[NL]         = ptr_l;
        chain_rp[NL]         = ptr_r;
        chain_acc[NL]        = is_query ? '0 : $unsigned(new_value);
    end

    // cell NL-1 holds the deepest level, cell 0 the root
    for (genvar j = 0; j < NL; j++)
    begin : g_cell
        segsum_cell #(
            .LEAVES (LEAVES),
            .LEVEL  (j)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_ctrl  (chain_ctrl[j+1]),
            .in_lp    (chain_lp[j+1]),
            .in_rp    (chain_rp[j+1]),
            .in_acc   (chain_acc[j+1]),
            .clr_en   (clearing_reg),
            .clr_addr (clr_cnt_reg),
            .out_ctrl (chain_ctrl[j]),
            .out_lp   (chain_lp[j]),
            .out_rp   (chain_rp[j]),
            .out_acc  (chain_acc[j])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                begin
                    clearing_reg <= 1'b0;
                end
            end

            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (chain_ctrl[0].valid)
            begin
                busy_reg <= 1'b0;
            end

            done_reg <= chain_ctrl[0].valid & chain_ctrl[0].query;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chain_ctrl[0].valid & chain_ctrl[0].query)
        begin
            range_sum_reg <= chain_acc[0];
        end
    end

    assign busy      = clearing_reg | busy_reg;
    assign done      = done_reg;
    assign range_sum = $signed(range_sum_reg);

endmodule

// File: src/segsum_checker.sv
// ----------------------------------------------------------------------------
// segsum_checker
// Port level checks of the segment tree range sum unit, bound to the top.
// ----------------------------------------------------------------------------
module segsum_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic                                 done,
    input logic signed [segsum_pkg::DATA_W-1:0] range_sum
);

    // an accepted request keeps the unit busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // a result only ends a request that was in flight
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a request in flight");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // the unit is ready again when the result shows
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("still busy while result is shown");

    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown(range_sum))
        else $error("unknown bits in result");

endmodule

bind segment_tree_point_set_range_sum_unit segsum_checker u_segsum_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .range_sum  (range_sum)
);
